FILE: rtl/core/bhto_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed hash table package
// Shared types and constants for the bucketed hash table with overflow.
// ----------------------------------------------------------------------------
`default_nettype none

package bhto_pkg;

    localparam int KEY_W = 64;
    localparam int SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int IN_VALUE_W = 32;

    // Operation codes; any other code behaves as a find.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_PRESENT  = 3'd1,
        STAT_FOUND    = 3'd2,
        STAT_MISSING  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_ZERO     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_BCHECK,
        S_OSCAN
    } state_t;

    // Outcome of comparing one bucket row against the search key.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   hit_slot;
        logic                empty;
        logic [SLOT_W-1:0]   empty_slot;
    } match_t;

endpackage

`default_nettype wire

FILE: rtl/core/bhto_bucket_match.sv
// ----------------------------------------------------------------------------
// Bucket row matcher
// Compares the eight keys of one bucket row with the search key and reports
// the first matching slot and the first empty slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bhto_bucket_match (
    input  wire logic [bhto_pkg::SLOTS-1:0][bhto_pkg::KEY_W-1:0] row_keys,
    input  wire logic [bhto_pkg::KEY_W-1:0]                      key,
    output bhto_pkg::match_t                                     match
);
    import bhto_pkg::*;

    // Priority scan from the highest slot down so the lowest slot wins.
    always_comb
    begin
        match = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (row_keys[s] == key)
            begin
                match.hit      = 1'b1;
                match.hit_slot = SLOT_W'(s);
            end
            if (row_keys[s] == '0)
            begin
                match.empty      = 1'b1;
                match.empty_slot = SLOT_W'(s);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bucketed_hash_table_with_overflow_top.sv
// ----------------------------------------------------------------------------
// Bucketed hash table with overflow
// Eight-way bucketed key store with a linearly scanned overflow table.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                         Handshake
// command   in         opcode, key, value              start & !busy
// result    out        status, found_value             done, one cycle
// config    in         cfg_data                        cfg_valid & cfg_ready
//
// A command answers after the bucket check on a bucket hit or zero key, and
// otherwise after scanning the overflow table from the start index up to its
// last entry, one entry per cycle through its read port. After reset a
// clearing pass empties both tables; busy is high meanwhile. The receiver
// cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_hash_table_with_overflow_top #(
    parameter int BUCKET_COUNT_LOG2 = 10,
    parameter int OVERFLOW_ENTRIES = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] key,
    input  wire logic [31:0] value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      found_value
);
    import bhto_pkg::*;

    localparam int ROWS = 1 << BUCKET_COUNT_LOG2;
    localparam int OW = $clog2(OVERFLOW_ENTRIES);
    localparam int ENT_W = KEY_W + VALUE_BITS;
    localparam int CLR_N = (ROWS > OVERFLOW_ENTRIES) ? ROWS : OVERFLOW_ENTRIES;
    localparam int CLW = $clog2(CLR_N);

    // Memories
    logic [SLOTS-1:0][ENT_W-1:0] bmem [ROWS];
    logic [ENT_W-1:0]            omem [OVERFLOW_ENTRIES];
    logic [SLOTS-1:0][ENT_W-1:0] brow_q;
    logic [ENT_W-1:0]            orow_q;

    // Control and payload registers
    state_t                  state_reg, state_next;
    logic [63:0]             salt_reg;
    logic [1:0]              op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [IN_VALUE_W-1:0]   val_reg, val_next;
    logic [BUCKET_COUNT_LOG2-1:0] bidx_reg, bidx_next;
    logic [OW:0]             ptr_reg, ptr_next;
    logic [OW-1:0]           chk_reg, chk_next;
    logic                    free_vld_reg, free_vld_next;
    logic                    free_ovf_reg, free_ovf_next;
    logic [SLOT_W-1:0]       free_slot_reg, free_slot_next;
    logic [OW-1:0]           free_idx_reg, free_idx_next;
    logic [CLW-1:0]          clr_reg, clr_next;
    logic                    done_reg, done_next;
    status_t                 status_reg, status_next;
    logic [31:0]             fval_reg, fval_next;

    // Memory port controls
    logic                    bre, bwe, ore, owe;
    logic [BUCKET_COUNT_LOG2-1:0] braddr;
    logic [SLOT_W-1:0]       bwslot;
    logic [OW-1:0]           oraddr, owaddr;
    logic [ENT_W-1:0]        wentry;
    logic                    bclr, oclr;

    // Derived values
    logic [KEY_W-1:0]        mixed_in, mixed_reg;
    logic [OW-1:0]           ostart;
    logic [VALUE_BITS-1:0]   wval;
    logic [SLOTS-1:0][KEY_W-1:0] row_keys;
    match_t                  bmatch;
    logic [KEY_W-1:0]        okey;
    logic [VALUE_BITS-1:0]   oval;
    logic                    last_ovf;

    assign mixed_in = key ^ salt_reg;
    assign mixed_reg = key_reg ^ salt_reg;
    assign ostart = mixed_reg[OW-1:0] & OW'(OVERFLOW_ENTRIES - 1);
    assign wval = VALUE_BITS'(val_reg);
    assign wentry = {key_reg, wval};
    assign okey = orow_q[ENT_W-1 -: KEY_W];
    assign oval = orow_q[VALUE_BITS-1:0];
    assign last_ovf = (chk_reg == OW'(OVERFLOW_ENTRIES - 1));
    assign bclr = (state_reg == S_CLEAR) && ({1'b0, clr_reg} < (CLW + 1)'(ROWS));
    assign oclr = (state_reg == S_CLEAR) && ({1'b0, clr_reg} < (CLW + 1)'(OVERFLOW_ENTRIES));

    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            row_keys[s] = brow_q[s][ENT_W-1 -: KEY_W];
        end
    end

    bhto_bucket_match u_match (
        .row_keys (row_keys),
        .key      (key_reg),
        .match    (bmatch)
    );

    // Bucket memory: whole-row read, single-slot write, full-row clear.
    // A removal writes an empty entry into the slot.
    always_ff @(posedge clk)
    begin
        if (bclr)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                bmem[clr_reg[BUCKET_COUNT_LOG2-1:0]][s] <= '0;
            end
        end
        else if (bwe)
        begin
            bmem[bidx_reg][bwslot] <= (op_reg == OP_INSERT) ? wentry : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bre)
        begin
            brow_q <= bmem[braddr];
        end
    end

    // Overflow memory: one entry read and one entry write per cycle.
    always_ff @(posedge clk)
    begin
        if (oclr)
        begin
            omem[clr_reg[OW-1:0]] <= '0;
        end
        else if (owe)
        begin
            omem[owaddr] <= (op_reg == OP_INSERT) ? wentry : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ore)
        begin
            orow_q <= omem[oraddr];
        end
    end

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            salt_reg <= cfg_data;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            done_reg <= 1'b0;
            free_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            done_reg <= done_next;
            free_vld_reg <= free_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        bidx_reg <= bidx_next;
        ptr_reg <= ptr_next;
        chk_reg <= chk_next;
        free_ovf_reg <= free_ovf_next;
        free_slot_reg <= free_slot_next;
        free_idx_reg <= free_idx_next;
        status_reg <= status_next;
        fval_reg <= fval_next;
    end

    // Sequencer: next state, memory controls and result.
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        bidx_next = bidx_reg;
        ptr_next = ptr_reg;
        chk_next = chk_reg;
        free_vld_next = free_vld_reg;
        free_ovf_next = free_ovf_reg;
        free_slot_next = free_slot_reg;
        free_idx_next = free_idx_reg;
        clr_next = clr_reg;
        done_next = 1'b0;
        status_next = status_reg;
        fval_next = fval_reg;
        bre = 1'b0;
        braddr = mixed_in[BUCKET_COUNT_LOG2-1:0];
        bwe = 1'b0;
        bwslot = free_slot_reg;
        ore = 1'b0;
        oraddr = ostart;
        owe = 1'b0;
        owaddr = chk_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode;
                    key_next = key;
                    val_next = value;
                    bidx_next = mixed_in[BUCKET_COUNT_LOG2-1:0];
                    bre = 1'b1;
                    free_vld_next = 1'b0;
                    state_next = S_BCHECK;
                end
            end

            S_BCHECK:
            begin
                fval_next = '0;
                if (key_reg == '0)
                begin
                    status_next = STAT_ZERO;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (bmatch.hit)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_INSERT)
                    begin
                        status_next = STAT_PRESENT;
                    end
                    else
                    begin
                        status_next = STAT_FOUND;
                        fval_next = 32'(brow_q[bmatch.hit_slot][VALUE_BITS-1:0]);
                        if (op_reg == OP_REMOVE)
                        begin
                            bwe = 1'b1;
                            bwslot = bmatch.hit_slot;
                        end
                    end
                end
                else
                begin
                    // Miss in the bucket: start the overflow scan.
                    free_vld_next = bmatch.empty;
                    free_ovf_next = 1'b0;
                    free_slot_next = bmatch.empty_slot;
                    ore = 1'b1;
                    oraddr = ostart;
                    chk_next = ostart;
                    ptr_next = {1'b0, ostart} + 1'b1;
                    state_next = S_OSCAN;
                end
            end

            S_OSCAN:
            begin
                fval_next = '0;
                if (okey == key_reg)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_INSERT)
                    begin
                        status_next = STAT_PRESENT;
                    end
                    else
                    begin
                        status_next = STAT_FOUND;
                        fval_next = 32'(oval);
                        if (op_reg == OP_REMOVE)
                        begin
                            owe = 1'b1;
                            owaddr = chk_reg;
                        end
                    end
                end
                else if (last_ovf)
                begin
                    done_next = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg != OP_INSERT)
                    begin
                        status_next = STAT_MISSING;
                    end
                    else if (free_vld_reg && !free_ovf_reg)
                    begin
                        status_next = STAT_INSERTED;
                        bwe = 1'b1;
                        bwslot = free_slot_reg;
                    end
                    else if (free_vld_reg)
                    begin
                        status_next = STAT_INSERTED;
                        owe = 1'b1;
                        owaddr = free_idx_reg;
                    end
                    else if (okey == '0)
                    begin
                        status_next = STAT_INSERTED;
                        owe = 1'b1;
                        owaddr = chk_reg;
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                end
                else
                begin
                    // Remember the first empty entry and fetch the next one.
                    if (!free_vld_reg && okey == '0)
                    begin
                        free_vld_next = 1'b1;
                        free_ovf_next = 1'b1;
                        free_idx_next = chk_reg;
                    end
                    ore = 1'b1;
                    oraddr = ptr_reg[OW-1:0];
                    chk_next = ptr_reg[OW-1:0];
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = status_reg;
    assign found_value = fval_reg;

endmodule

`default_nettype wire

FILE: rtl/core/bhto_checker.sv
// ----------------------------------------------------------------------------
// Bucketed hash table port checker
// Watches the top-level ports for command and result sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

module bhto_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic [31:0] found_value
);
    import bhto_pkg::*;

    // An accepted word keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting a word");

    // A result never appears right after a word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobed one cycle after acceptance");

    // Result strobes never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // Only defined status codes are reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= STAT_ZERO))
        else $error("undefined status code");

    // A value is returned only with a found status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_FOUND) |-> (found_value == '0))
        else $error("nonzero value without a found status");

endmodule

bind bucketed_hash_table_with_overflow_top bhto_checker u_bhto_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .found_value (found_value)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table command testbench
// Drives insert, find and remove commands and salt writes into the bucketed
// hash table, predicts every status word with its own table copy, and checks
// each result word as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;
    import bhto_pkg::*;

    localparam int NBUCKET_LOG2 = 10;
    localparam int NOVF = 64;
    localparam int NSLOT_TOTAL = (1 << NBUCKET_LOG2) * SLOTS;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key;
        logic [31:0] value;
    } command_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_value;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [31:0] value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;
    logic        done;
    logic [2:0]  status;
    logic [31:0] found_value;

    bucketed_hash_table_with_overflow_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .key(key), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .status(status), .found_value(found_value)
    );

    // Predictor state: shadow copy of both tables and the salt.
    logic [63:0] shadow_salt;
    logic [63:0] shadow_bkey [NSLOT_TOTAL];
    logic [31:0] shadow_bval [NSLOT_TOTAL];
    logic [63:0] shadow_okey [NOVF];
    logic [31:0] shadow_oval [NOVF];

    command_t pending_cmds[$];
    answer_t  expected_answers[$];
    logic [63:0] used_keys[$];
    int  errors = 0;
    bit  quiet = 0;
    int  idle_left = 0;

    // Apply one command to the shadow tables and return its answer.
    function automatic answer_t lookup_and_update(command_t c);
        answer_t a;
        logic [63:0] mixed;
        int base, first, hit, free_at;
        bit hit_ovf, free_ovf, found, has_free;
        a.status = STAT_ZERO;
        a.found_value = '0;
        found = 0; has_free = 0; hit = 0; free_at = 0; hit_ovf = 0; free_ovf = 0;
        if (c.key == 64'd0)
            return a;
        mixed = c.key ^ shadow_salt;
        base = int'(mixed[NBUCKET_LOG2-1:0]) * SLOTS;
        first = int'(mixed[5:0]);
        for (int i = 0; i < SLOTS && !found; i++) begin
            if (shadow_bkey[base+i] == c.key) begin
                found = 1; hit = base + i; hit_ovf = 0;
            end else if (shadow_bkey[base+i] == 64'd0 && !has_free) begin
                has_free = 1; free_at = base + i; free_ovf = 0;
            end
        end
        for (int i = first; i < NOVF && !found; i++) begin
            if (shadow_okey[i] == c.key) begin
                found = 1; hit = i; hit_ovf = 1;
            end else if (shadow_okey[i] == 64'd0 && !has_free) begin
                has_free = 1; free_at = i; free_ovf = 1;
            end
        end
        if (c.opcode == OP_INSERT) begin
            if (found)
                a.status = STAT_PRESENT;
            else if (!has_free)
                a.status = STAT_FULL;
            else begin
                a.status = STAT_INSERTED;
                if (free_ovf) begin
                    shadow_okey[free_at] = c.key; shadow_oval[free_at] = c.value;
                end else begin
                    shadow_bkey[free_at] = c.key; shadow_bval[free_at] = c.value;
                end
            end
        end else if (!found)
            a.status = STAT_MISSING;
        else begin
            a.status = STAT_FOUND;
            if (hit_ovf) begin
                a.found_value = shadow_oval[hit];
                if (c.opcode == OP_REMOVE) begin
                    shadow_okey[hit] = '0; shadow_oval[hit] = '0;
                end
            end else begin
                a.found_value = shadow_bval[hit];
                if (c.opcode == OP_REMOVE) begin
                    shadow_bkey[hit] = '0; shadow_bval[hit] = '0;
                end
            end
        end
        return a;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keys that share one bucket and one overflow start under the salt.
    function automatic logic [63:0] crowded_key(logic [63:0] s, int bucket);
        logic [63:0] k;
        k = rand64();
        k[NBUCKET_LOG2-1:0] = bucket[NBUCKET_LOG2-1:0] ^ s[NBUCKET_LOG2-1:0];
        return k;
    endfunction

    task automatic push_cmd(logic [1:0] op, logic [63:0] k, logic [31:0] v);
        command_t c;
        c.opcode = op; c.key = k; c.value = v;
        pending_cmds.push_back(c);
        if (k != 0) used_keys.push_back(k);
    endtask

    // Wait until the block has drained every queued command and result.
    task automatic drain();
        while (pending_cmds.size() != 0 || expected_answers.size() != 0 || busy || start)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_salt(logic [63:0] s);
        cfg_data <= s;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_salt = s;
    endtask

    // Random traffic with a reused key pool and one crowded bucket.
    task automatic random_phase(int count, logic [63:0] s);
        int hot;
        logic [63:0] k;
        hot = $urandom_range(0, (1 << NBUCKET_LOG2) - 1);
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: k = crowded_key(s, hot);
                3:       k = ($urandom_range(0, 15) == 0) ? 64'd0 : rand64();
                default: k = (used_keys.size() != 0)
                    ? used_keys[$urandom_range(0, used_keys.size() - 1)] : rand64();
            endcase
            push_cmd(2'($urandom_range(0, 3)), k, $urandom);
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Command driver: issues queued words with random idle bursts unless quiet is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            opcode <= '0;
            key <= '0;
            value <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_answers.push_back(lookup_and_update({opcode, key, value}));
            if (start && busy)
                ;
            else if (idle_left > 0)
            begin
                start <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_cmds.size() != 0 && !(start && pending_cmds.size() == 0))
            begin
                command_t c;
                c = pending_cmds.pop_front();
                start <= 1'b1;
                opcode <= c.opcode;
                key <= c.key;
                value <= c.value;
                if (!quiet && $urandom_range(0, 4) == 0)
                    idle_left <= $urandom_range(1, 6);
            end
            else
                start <= 1'b0;
        end
    end

    // Result monitor: compares each result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result word with no prediction: status %0d", status);
                errors++;
            end
            else
            begin
                answer_t a;
                a = expected_answers.pop_front();
                if (status !== a.status)
                begin
                    $error("status: expected %0d, actual %0d", a.status, status);
                    errors++;
                end
                if (found_value !== a.found_value)
                begin
                    $error("found_value: expected %h, actual %h", a.found_value, found_value);
                    errors++;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [63:0] k;
        for (int i = 0; i < NSLOT_TOTAL; i++)
        begin
            shadow_bkey[i] = '0; shadow_bval[i] = '0;
        end
        for (int i = 0; i < NOVF; i++)
        begin
            shadow_okey[i] = '0; shadow_oval[i] = '0;
        end
        shadow_salt = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_salt('1);

        // Directed: zero key, extremes, all opcodes, duplicate, removal.
        push_cmd(OP_INSERT, 64'd0, 32'hFFFF_FFFF);
        push_cmd(OP_FIND, 64'd0, 32'd0);
        push_cmd(OP_INSERT, '1, '1);
        push_cmd(OP_INSERT, '1, 32'd5);
        push_cmd(OP_FIND, '1, 32'd0);
        push_cmd(2'd3, '1, 32'd0);
        push_cmd(OP_REMOVE, '1, 32'd0);
        push_cmd(OP_REMOVE, '1, 32'd0);
        push_cmd(OP_FIND, 64'd1, 32'd0);
        push_cmd(2'd3, 64'h5555_5555_5555_5555, 32'd0);
        drain();

        // Fill one bucket and its overflow tail to reach full.
        write_salt('0);
        for (int i = 0; i < 12; i++)
            push_cmd(OP_INSERT, {52'(i + 1), 12'h3FF}, 32'hA000_0000 + i);
        push_cmd(OP_FIND, {52'd10, 12'h3FF}, 32'd0);
        push_cmd(OP_REMOVE, {52'd3, 12'h3FF}, 32'd0);
        push_cmd(OP_INSERT, {52'd99, 12'h3FF}, 32'h1234);
        push_cmd(OP_FIND, {52'd99, 12'h3FF}, 32'd0);
        push_cmd(OP_REMOVE, {52'd12, 12'h3FF}, 32'd0);
        drain();

        // Random phases over several salts.
        for (int p = 0; p < 4; p++)
        begin
            k = (p == 3) ? 64'h0 : rand64();
            write_salt(k);
            if (p == 3) quiet = 1;
            random_phase(220, k);
            drain();
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Timeout.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: bucketed_hash_table_with_overflow_top.f
rtl/core/bhto_pkg.sv
rtl/core/bhto_bucket_match.sv
rtl/core/bucketed_hash_table_with_overflow_top.sv
rtl/core/bhto_checker.sv
test/testbench.sv
